### rtl/core/lrm_pkg.sv
package lrm_pkg;

  localparam logic [7:0] LINE_FEED = 8'h0A;
  localparam logic [7:0] ANY_CHAR  = 8'h2E;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_EOI  = 1'b1
  } cmd_t;

  typedef enum logic {
    KIND_LINE    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  localparam logic [2:0] REG_ATOM_COUNT   = 3'd0;
  localparam logic [2:0] REG_CHARS_LOW    = 3'd1;
  localparam logic [2:0] REG_CHARS_HIGH   = 3'd2;
  localparam logic [2:0] REG_STAR_MASK    = 3'd3;
  localparam logic [2:0] REG_ANCHOR_START = 3'd4;
  localparam logic [2:0] REG_ANCHOR_END   = 3'd5;
  localparam logic [2:0] REG_NEVER_MATCH  = 3'd6;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic        result_kind;
    logic        line_matched;
    logic [31:0] line_idx;
    logic        any_found;
    logic        last;
  } out_req_t;

  typedef struct packed {
    logic       step;
    logic       restart;
    logic [7:0] data_byte;
  } cell_ctl_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       star;
    logic       en;
  } atom_t;

  typedef struct packed {
    logic clos;
    logic adv;
  } link_t;

endpackage

### rtl/core/lrm_cell.sv
module lrm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  lrm_pkg::cell_ctl_t ctl,
  input  lrm_pkg::atom_t    atom,
  input  logic              rst_val,
  input  lrm_pkg::link_t    link_in,
  output lrm_pkg::link_t    link_out,
  output logic              closed
);
  import lrm_pkg::*;

  logic act_r;
  logic act_nxt;
  logic hit;

  // The position is live if it was active or a starred atom to the left can be skipped.
  assign closed = act_r | link_in.clos;
  assign hit    = closed & atom.en & ((atom.chr == ANY_CHAR) || (atom.chr == ctl.data_byte));

  assign link_out.clos = closed & atom.en & atom.star;
  assign link_out.adv  = hit & ~atom.star;

  always_comb begin
    act_nxt = act_r;
    if (ctl.restart) begin
      act_nxt = rst_val;
    end else if (ctl.step) begin
      act_nxt = (hit & atom.star) | link_in.adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= rst_val;
    end else begin
      act_r <= act_nxt;
    end
  end

endmodule

### rtl/core/line_regex_matcher.sv
// Line matcher for a small pattern language of literal or any-byte atoms, each optionally
// starred, with optional start and end anchors. It takes one byte request per clock, with no
// gaps while in_stall is low; the active-position set lives in a row of ATOMS cells, and the
// skip over starred atoms ripples through that row inside the same cycle, which sets the clock.
// A line feed gives one verdict, end of input gives a verdict for a pending partial line and
// then a summary. Results are registered into a four-entry queue; in_stall rises only while
// fewer than two queue slots are free, so with the output side taking one result per clock the
// block sustains one request per clock.
module line_regex_matcher #(
  parameter int ATOMS    = 16,
  parameter int MAX_LINE = 4095
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lrm_pkg::in_req_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lrm_pkg::out_req_t out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_wdata
);
  import lrm_pkg::*;

  localparam int NW = $clog2(ATOMS + 1);
  localparam int LW = $clog2(MAX_LINE + 1);
  localparam int QDEPTH = 4;
  localparam int QW = $clog2(QDEPTH);

  logic [4:0]  cnt_cfg_r;
  logic [63:0] chars_lo_r;
  logic [63:0] chars_hi_r;
  logic [15:0] star_r;
  logic        anch_s_r;
  logic        anch_e_r;
  logic        never_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_cfg_r  <= '0;
      chars_lo_r <= '0;
      chars_hi_r <= '0;
      star_r     <= '0;
      anch_s_r   <= 1'b0;
      anch_e_r   <= 1'b0;
      never_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATOM_COUNT:   cnt_cfg_r  <= cfg_wdata[4:0];
        REG_CHARS_LOW:    chars_lo_r <= cfg_wdata;
        REG_CHARS_HIGH:   chars_hi_r <= cfg_wdata;
        REG_STAR_MASK:    star_r     <= cfg_wdata[15:0];
        REG_ANCHOR_START: anch_s_r   <= cfg_wdata[0];
        REG_ANCHOR_END:   anch_e_r   <= cfg_wdata[0];
        REG_NEVER_MATCH:  never_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] n_eff;
  assign n_eff = (32'(cnt_cfg_r) > 32'(ATOMS)) ? NW'(ATOMS) : NW'(cnt_cfg_r);

  logic [QW:0]   cnt_r, cnt_nxt;
  logic [QW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0] rd_ptr_r, rd_ptr_nxt;
  out_req_t      fifo_r [QDEPTH];

  logic acc, pop, is_nl, is_eoi, is_data, step, restart;
  logic [LW-1:0] len_r, len_nxt;
  logic          line_acc_r, line_acc_nxt;
  logic [31:0]   line_r, line_nxt;
  logic          found_r, found_nxt;
  logic          act_last_r, act_last_nxt;

  assign in_stall  = (cnt_r > (QW+1)'(QDEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_data  = fifo_r[rd_ptr_r];
  assign acc       = in_valid & ~in_stall;
  assign pop       = out_valid & ~out_stall;

  assign is_eoi  = acc & (in_data.command == CMD_EOI);
  assign is_nl   = acc & (in_data.command == CMD_DATA) & (in_data.data_byte == LINE_FEED);
  assign is_data = acc & (in_data.command == CMD_DATA) & (in_data.data_byte != LINE_FEED);
  assign step    = is_data & (len_r < LW'(MAX_LINE));
  assign restart = is_nl | is_eoi;

  cell_ctl_t     ctl;
  link_t         lk [ATOMS+1];
  logic [ATOMS:0] cvec;

  assign ctl.step      = step;
  assign ctl.restart   = restart;
  assign ctl.data_byte = in_data.data_byte;

  assign lk[0].clos = 1'b0;
  assign lk[0].adv  = ~anch_s_r;

  for (genvar i = 0; i < ATOMS; i++) begin : g_cell
    atom_t atom;
    logic  rv;
    if (i < 8) begin : g_lo
      assign atom.chr  = chars_lo_r[8*i +: 8];
      assign atom.star = star_r[i];
    end else if (i < 16) begin : g_hi
      assign atom.chr  = chars_hi_r[8*(i-8) +: 8];
      assign atom.star = star_r[i];
    end else begin : g_none
      assign atom.chr  = 8'h00;
      assign atom.star = 1'b0;
    end
    assign atom.en = (NW'(i) < n_eff);
    assign rv = (i == 0) ? 1'b1 : 1'b0;

    lrm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .atom     (atom),
      .rst_val  (rv),
      .link_in  (lk[i]),
      .link_out (lk[i+1]),
      .closed   (cvec[i])
    );
  end

  assign cvec[ATOMS] = act_last_r | lk[ATOMS].clos;

  logic c_n, verdict;
  assign c_n     = cvec[n_eff];
  assign verdict = ~never_r & (anch_e_r ? c_n : (line_acc_r | c_n));

  out_req_t r0, r1;
  logic [1:0] npush;
  logic       pending;

  assign pending = (len_r != '0);

  always_comb begin
    r0 = '0;
    r1 = '0;
    npush = 2'd0;
    r1.result_kind = KIND_SUMMARY;
    r1.line_idx    = line_r;
    r1.any_found   = found_r | verdict;
    r1.last        = 1'b1;
    if (is_nl) begin
      npush = 2'd1;
      r0.result_kind  = KIND_LINE;
      r0.line_matched = verdict;
      r0.line_idx     = line_r;
      r0.any_found    = found_r | verdict;
      r0.last         = 1'b1;
    end else if (is_eoi && pending) begin
      npush = 2'd2;
      r0.result_kind  = KIND_LINE;
      r0.line_matched = verdict;
      r0.line_idx     = line_r;
      r0.any_found    = found_r | verdict;
      r0.last         = 1'b0;
    end else if (is_eoi) begin
      npush = 2'd1;
      r0.result_kind  = KIND_SUMMARY;
      r0.line_idx     = line_r;
      r0.any_found    = found_r;
      r0.last         = 1'b1;
    end
  end

  always_comb begin
    len_nxt      = len_r;
    line_acc_nxt = line_acc_r;
    line_nxt     = line_r;
    found_nxt    = found_r;
    act_last_nxt = act_last_r;
    if (step) begin
      len_nxt      = len_r + LW'(1);
      line_acc_nxt = line_acc_r | c_n;
      act_last_nxt = lk[ATOMS].adv;
    end
    if (restart) begin
      len_nxt      = '0;
      line_acc_nxt = 1'b0;
      act_last_nxt = 1'b0;
    end
    if (is_nl) begin
      found_nxt = found_r | verdict;
      line_nxt  = (line_r != '1) ? line_r + 32'd1 : line_r;
    end
    if (is_eoi) begin
      found_nxt = 1'b0;
      line_nxt  = 32'd1;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QW'(npush);
    rd_ptr_nxt = rd_ptr_r + QW'(pop);
    cnt_nxt    = cnt_r + (QW+1)'(npush) - (QW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      len_r      <= '0;
      line_acc_r <= 1'b0;
      line_r     <= 32'd1;
      found_r    <= 1'b0;
      act_last_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      len_r      <= len_nxt;
      line_acc_r <= line_acc_nxt;
      line_r     <= line_nxt;
      found_r    <= found_nxt;
      act_last_r <= act_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (npush != 2'd0) begin
      fifo_r[wr_ptr_r] <= r0;
    end
    if (npush == 2'd2) begin
      fifo_r[wr_ptr_r + QW'(1)] <= r1;
    end
  end

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QW+1)'(QDEPTH))
    else $error("result queue overflow");

  a_line_push: assert property (@(posedge clk) disable iff (!rst_n)
    is_nl && !pop |=> cnt_r == $past(cnt_r) + (QW+1)'(1))
    else $error("line verdict not queued");

  a_eoi_restart: assert property (@(posedge clk) disable iff (!rst_n)
    is_eoi |=> line_r == 32'd1 && !found_r && len_r == '0)
    else $error("counters not restarted after end of input");
`endif

endmodule
